### hdl/pgcs_pkg.sv
// shared constants, codes and saturating helpers for the particle step block
package pgcs_pkg;

    localparam int MAX_PARTICLES = 32;
    localparam int IDX_W         = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
    localparam int IDX_OUT_W     = 5;
    localparam int DATA_W        = 24;
    localparam int D2_W          = 2 * DATA_W + 2;
    localparam int ADDR_W        = 4;
    localparam int APB_DATA_W    = 32;

    localparam logic [1:0] STATUS_SPAWN_OK = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_TICK     = 2'd2;

    localparam logic [1:0] REG_GRAVITY = 2'd0;
    localparam logic [1:0] REG_TSTEP   = 2'd1;
    localparam logic [1:0] REG_CONTACT = 2'd2;

    localparam logic       OP_SPAWN = 1'b0;
    localparam logic       OP_TICK  = 1'b1;

    localparam logic [15:0] GRAVITY_RST = 16'd251;
    localparam logic [7:0]  TSTEP_RST   = 8'd26;
    localparam logic [15:0] CONTACT_RST = 16'd2560;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // clamp a two-bit-wider signed sum to the field range
    function automatic logic signed [DATA_W-1:0] sat24(input logic signed [DATA_W+1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > $signed({{2{1'b0}}, SAT_MAX}))
            r = SAT_MAX;
        else if (v < $signed({{2{1'b1}}, SAT_MIN}))
            r = SAT_MIN;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] neg_sat24(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v == SAT_MIN)
            r = SAT_MAX;
        else
            r = -v;
        return r;
    endfunction

endpackage

### hdl/particle_gravity_collision_step.sv
// particle store with gravity, motion and contact bounce
// Usage: a command is taken on a rising edge with start high and busy low.
// operation 0 spawns a particle at (spawn_x, spawn_y) in whole pixels; the
// single result (status spawn ok or store full) shows in the next cycle.
// operation 1 runs a tick; with no particles one empty report follows in the
// next cycle, otherwise one report per particle, in index order, with last
// set on the final one. Each result is on the ports for exactly one cycle,
// flagged by result_valid; the receiver cannot stall and must take it.
// A tick runs a motion pass, then a contact pass and the report stream; the
// contact pass does one pair compare per cycle through the single read port.
// busy stays high until the last result has been registered.
// Reset empties the store (live count zero) and loads the register defaults;
// the four particle memories are not cleared, entries past the count are
// never used. The APB port is written only while busy is low: this binds
// the user, the block itself does not enforce it.
module particle_gravity_collision_step
    import pgcs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_W-1:0]           paddr,
    input  logic [APB_DATA_W-1:0]       pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic                        operation,
    input  logic [9:0]                  spawn_x,
    input  logic [9:0]                  spawn_y,
    output logic                        result_valid,
    output logic [1:0]                  status,
    output logic [IDX_OUT_W-1:0]        particle_index,
    output logic                        present,
    output logic signed [DATA_W-1:0]    pos_x,
    output logic signed [DATA_W-1:0]    pos_y,
    output logic signed [DATA_W-1:0]    vel_x,
    output logic signed [DATA_W-1:0]    vel_y,
    output logic                        last
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_MV_RD    = 8'b0000_0010,
        ST_MV_VEL   = 8'b0000_0100,
        ST_MV_WR    = 8'b0000_1000,
        ST_CL_LOAD  = 8'b0001_0000,
        ST_CL_LATCH = 8'b0010_0000,
        ST_CL_SCAN  = 8'b0100_0000,
        ST_RPT      = 8'b1000_0000
    } state_t;

    // configuration
    logic [15:0] gravity_step_reg;
    logic [7:0]  time_step_reg;
    logic [15:0] contact_distance_reg;
    logic        cfg_wr;

    // control
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        live_count_reg, live_count_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        j_reg, j_next;
    logic                    s0_valid_reg, s0_valid_next;
    logic                    s1_valid_reg, s2_valid_reg;
    logic                    hit_acc_reg, hit_acc_next;
    logic [MAX_PARTICLES-1:0] hit_vec_reg, hit_vec_next;
    logic                    r_valid_reg, r_valid_next;
    logic [IDX_W-1:0]        r_idx_reg, r_idx_next;
    logic                    r_last_reg, r_last_next;
    logic                    result_valid_reg;
    logic                    accept;
    logic                    idx_is_final;

    // memories
    logic signed [DATA_W-1:0] px_mem [MAX_PARTICLES];
    logic signed [DATA_W-1:0] py_mem [MAX_PARTICLES];
    logic signed [DATA_W-1:0] vx_mem [MAX_PARTICLES];
    logic signed [DATA_W-1:0] vy_mem [MAX_PARTICLES];
    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W-1:0]         wr_addr;
    logic                     mem_we;
    logic signed [DATA_W-1:0] wd_px, wd_py, wd_vx, wd_vy;
    logic signed [DATA_W-1:0] rd_px, rd_py, rd_vx, rd_vy;

    // datapath
    logic [31:0]              lim_reg;
    logic signed [DATA_W-1:0] mv_px_reg, mv_py_reg, mv_vx_reg, mv_vy_reg;
    logic signed [DATA_W-1:0] vy_grav;
    logic signed [DATA_W+8:0] prod_x, prod_y;
    logic signed [DATA_W-1:0] new_px, new_py;
    logic signed [DATA_W-1:0] pi_x_reg, pi_y_reg;
    logic signed [DATA_W:0]   dx_reg, dy_reg;
    logic signed [2*DATA_W+1:0] sqx_full, sqy_full;
    logic [2*DATA_W:0]        sqx_reg, sqy_reg;
    logic [D2_W-1:0]          d2;
    logic                     near;
    logic signed [DATA_W-1:0] rpt_vx, rpt_vy;

    // result staging
    logic                     out_load;
    logic [1:0]               out_status;
    logic [IDX_W-1:0]         out_idx;
    logic                     out_present;
    logic signed [DATA_W-1:0] out_px, out_py, out_vx, out_vy;
    logic                     out_last;

    // ---------------------------------------------------------------- apb
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_step_reg     <= GRAVITY_RST;
            time_step_reg        <= TSTEP_RST;
            contact_distance_reg <= CONTACT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_GRAVITY: gravity_step_reg     <= pwdata[15:0];
                REG_TSTEP:   time_step_reg        <= pwdata[7:0];
                REG_CONTACT: contact_distance_reg <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_GRAVITY: prdata = {16'b0, gravity_step_reg};
            REG_TSTEP:   prdata = {24'b0, time_step_reg};
            REG_CONTACT: prdata = {16'b0, contact_distance_reg};
            default:     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- memories
    // the read made while the motion pass writes an entry back is never used,
    // the report writes back behind the read pointer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            px_mem[wr_addr] <= wd_px;
            py_mem[wr_addr] <= wd_py;
            vx_mem[wr_addr] <= wd_vx;
            vy_mem[wr_addr] <= wd_vy;
        end
        rd_px <= px_mem[rd_addr];
        rd_py <= py_mem[rd_addr];
        rd_vx <= vx_mem[rd_addr];
        rd_vy <= vy_mem[rd_addr];
    end

    // ---------------------------------------------------------------- arithmetic
    assign vy_grav = sat24($signed({{2{rd_vy[DATA_W-1]}}, rd_vy})
                           + $signed({10'b0, gravity_step_reg}));

    // arithmetic shift of the product floors the displacement
    assign prod_x = mv_vx_reg * $signed({1'b0, time_step_reg});
    assign prod_y = mv_vy_reg * $signed({1'b0, time_step_reg});
    assign new_px = sat24($signed({{2{mv_px_reg[DATA_W-1]}}, mv_px_reg})
                          + $signed({prod_x[DATA_W+8], prod_x[DATA_W+8:8]}));
    assign new_py = sat24($signed({{2{mv_py_reg[DATA_W-1]}}, mv_py_reg})
                          + $signed({prod_y[DATA_W+8], prod_y[DATA_W+8:8]}));

    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;
    assign d2       = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign near     = d2 <= D2_W'(lim_reg);

    assign rpt_vx = hit_vec_reg[r_idx_reg] ? neg_sat24(rd_vx) : rd_vx;
    assign rpt_vy = hit_vec_reg[r_idx_reg] ? neg_sat24(rd_vy) : rd_vy;

    always_ff @(posedge clk)
    begin
        if (accept)
            lim_reg <= contact_distance_reg * contact_distance_reg;
        if (state_reg == ST_MV_VEL)
        begin
            mv_px_reg <= rd_px;
            mv_py_reg <= rd_py;
            mv_vx_reg <= rd_vx;
            mv_vy_reg <= vy_grav;
        end
        if (state_reg == ST_CL_LATCH)
        begin
            pi_x_reg <= rd_px;
            pi_y_reg <= rd_py;
        end
        dx_reg  <= $signed({pi_x_reg[DATA_W-1], pi_x_reg}) - $signed({rd_px[DATA_W-1], rd_px});
        dy_reg  <= $signed({pi_y_reg[DATA_W-1], pi_y_reg}) - $signed({rd_py[DATA_W-1], rd_py});
        sqx_reg <= sqx_full[2*DATA_W:0];
        sqy_reg <= sqy_full[2*DATA_W:0];
    end

    // ---------------------------------------------------------------- control
    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign idx_is_final = (idx_reg + CNT_W'(1)) == live_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        live_count_next = live_count_reg;
        idx_next        = idx_reg;
        j_next          = j_reg;
        s0_valid_next   = 1'b0;
        hit_acc_next    = hit_acc_reg;
        hit_vec_next    = hit_vec_reg;
        r_valid_next    = 1'b0;
        r_idx_next      = r_idx_reg;
        r_last_next     = r_last_reg;
        rd_addr         = idx_reg[IDX_W-1:0];
        wr_addr         = idx_reg[IDX_W-1:0];
        mem_we          = 1'b0;
        wd_px           = new_px;
        wd_py           = new_py;
        wd_vx           = mv_vx_reg;
        wd_vy           = mv_vy_reg;
        out_load        = 1'b0;
        out_status      = STATUS_TICK;
        out_idx         = '0;
        out_present     = 1'b0;
        out_px          = '0;
        out_py          = '0;
        out_vx          = '0;
        out_vy          = '0;
        out_last        = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_SPAWN)
                    begin
                        out_load = 1'b1;
                        if (live_count_reg == CNT_W'(MAX_PARTICLES))
                        begin
                            out_status = STATUS_FULL;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            wr_addr         = live_count_reg[IDX_W-1:0];
                            wd_px           = $signed({{(DATA_W-18){1'b0}}, spawn_x, 8'b0});
                            wd_py           = $signed({{(DATA_W-18){1'b0}}, spawn_y, 8'b0});
                            wd_vx           = '0;
                            wd_vy           = '0;
                            out_status      = STATUS_SPAWN_OK;
                            out_idx         = live_count_reg[IDX_W-1:0];
                            out_present     = 1'b1;
                            out_px          = wd_px;
                            out_py          = wd_py;
                            live_count_next = live_count_reg + CNT_W'(1);
                        end
                    end
                    else if (live_count_reg == '0)
                    begin
                        out_load = 1'b1;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_MV_RD;
                    end
                end
            end

            ST_MV_RD:
            begin
                state_next = ST_MV_VEL;
            end

            ST_MV_VEL:
            begin
                state_next = ST_MV_WR;
            end

            ST_MV_WR:
            begin
                mem_we = 1'b1;
                if (idx_is_final)
                begin
                    idx_next   = '0;
                    state_next = ST_CL_LOAD;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_MV_RD;
                end
            end

            ST_CL_LOAD:
            begin
                state_next = ST_CL_LATCH;
            end

            ST_CL_LATCH:
            begin
                j_next       = '0;
                hit_acc_next = 1'b0;
                state_next   = ST_CL_SCAN;
            end

            ST_CL_SCAN:
            begin
                // three-stage compare pipe: difference, squares, sum and compare
                if (j_reg < live_count_reg)
                begin
                    rd_addr       = j_reg[IDX_W-1:0];
                    s0_valid_next = (j_reg != idx_reg);
                    j_next        = j_reg + CNT_W'(1);
                end
                hit_acc_next = hit_acc_reg || (s2_valid_reg && near);
                if ((j_reg == live_count_reg) && !s0_valid_reg && !s1_valid_reg
                    && !s2_valid_reg)
                begin
                    hit_vec_next[idx_reg[IDX_W-1:0]] = hit_acc_reg;
                    if (idx_is_final)
                    begin
                        idx_next   = '0;
                        state_next = ST_RPT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = ST_CL_LOAD;
                    end
                end
            end

            ST_RPT:
            begin
                if (idx_reg < live_count_reg)
                begin
                    r_valid_next = 1'b1;
                    r_idx_next   = idx_reg[IDX_W-1:0];
                    r_last_next  = idx_is_final;
                    idx_next     = idx_reg + CNT_W'(1);
                end
                if (r_valid_reg)
                begin
                    mem_we      = 1'b1;
                    wr_addr     = r_idx_reg;
                    wd_px       = rd_px;
                    wd_py       = rd_py;
                    wd_vx       = rpt_vx;
                    wd_vy       = rpt_vy;
                    out_load    = 1'b1;
                    out_idx     = r_idx_reg;
                    out_present = 1'b1;
                    out_px      = rd_px;
                    out_py      = rd_py;
                    out_vx      = rpt_vx;
                    out_vy      = rpt_vy;
                    out_last    = r_last_reg;
                    if (r_last_reg)
                        state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            live_count_reg   <= '0;
            idx_reg          <= '0;
            j_reg            <= '0;
            s0_valid_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            hit_acc_reg      <= 1'b0;
            r_valid_reg      <= 1'b0;
            r_idx_reg        <= '0;
            r_last_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            live_count_reg   <= live_count_next;
            idx_reg          <= idx_next;
            j_reg            <= j_next;
            s0_valid_reg     <= s0_valid_next;
            s1_valid_reg     <= s0_valid_reg;
            s2_valid_reg     <= s1_valid_reg;
            hit_acc_reg      <= hit_acc_next;
            r_valid_reg      <= r_valid_next;
            r_idx_reg        <= r_idx_next;
            r_last_reg       <= r_last_next;
            result_valid_reg <= out_load;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_vec_reg <= hit_vec_next;
        if (out_load)
        begin
            status         <= out_status;
            particle_index <= IDX_OUT_W'(out_idx);
            present        <= out_present;
            pos_x          <= out_px;
            pos_y          <= out_py;
            vel_x          <= out_vx;
            vel_y          <= out_vy;
            last           <= out_last;
        end
    end

    assign result_valid = result_valid_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_count_reg <= CNT_W'(MAX_PARTICLES))
        else $error("particle count above store size");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || result_valid))
        else $error("accepted transaction produced neither work nor result");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("busy still high after final result");

    a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RPT) |-> (!s0_valid_reg && !s1_valid_reg && !s2_valid_reg))
        else $error("compare pipe not empty during report");
`endif

endmodule
